// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker module of the decoder.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on i_clk, switched off while reset is low.
`define URLPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Concurrent assertion sampled on i_clk that also holds around reset.
`define URLPD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/urlpd_pkg.sv =====
// Shared types, character constants and helper functions of the URL percent decoder.
// No dependencies; the top level, front, queue and back import this package.
`default_nettype none

package urlpd_pkg;

    // Character codes.
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_F    = 8'h46;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_F    = 8'h66;
    localparam logic [3:0] NIB_TEN    = 4'd10;

    // Default depth of the queue between front and back.
    localparam int Q_DEPTH = 4;

    // Largest number of decoded bytes one input item can cause.
    localparam int MAX_RES = 3;

    // Escape tracking state of the front end.
    typedef enum logic [1:0] {
        HOLD_NONE  = 2'd0,
        HOLD_PCT   = 2'd1,
        HOLD_DIGIT = 2'd2
    } t_hold;

    // Result of a hex digit lookup.
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    // Work record passed from the front end to the back end: the decoded
    // bytes caused by one input item, how many of them are used, and
    // whether the item closed the string.
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] bytes;
        logic [1:0]              cnt;
        logic                    last;
    } t_cmd;

    // Classify a byte as a hex digit of either case and return its value.
    function automatic t_hex hex_nibble(input logic [7:0] c);
        t_hex r;
        r.ok  = 1'b0;
        r.val = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            r.ok  = 1'b1;
            r.val = 4'(c - CH_ZERO);
        end else if (c >= CH_UP_A && c <= CH_UP_F) begin
            r.ok  = 1'b1;
            r.val = 4'(c - CH_UP_A) + NIB_TEN;
        end else if (c >= CH_LO_A && c <= CH_LO_F) begin
            r.ok  = 1'b1;
            r.val = 4'(c - CH_LO_A) + NIB_TEN;
        end
        return r;
    endfunction

    // A plus sign stands for a space; every other byte passes unchanged.
    function automatic logic [7:0] plain_map(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/url_percent_decoder.sv =====
// URL percent decoder: stream in, one encoded byte per item; stream out, decoded bytes.
// Top level joining urlpd_front, urlpd_queue and urlpd_back; depends on urlpd_pkg.
//
// Usage:
//   The slave channel takes one raw byte per item in s_tdata, with s_tlast on the
//   final byte of a string. The master channel gives one decoded byte per item in
//   m_tdata; m_tuser marks the last result caused by one input item and m_tlast
//   marks the final decoded byte of the string.
//   '+' becomes a space, '%' with two hex digits becomes one byte, an invalid or
//   cut-off escape goes out literally.
// Timing:
//   An input byte's record is written into the record queue, then loaded into the
//   output register, where its first result shows. Bytes that give one result
//   flow at one item per cycle while the output is not stalled; an invalid escape
//   gives up to three results, which leave one per cycle through the output
//   register when not stalled. A byte that only extends a pending escape gives
//   no result. The record queue (QUEUE_DEPTH entries) lets the input keep flowing
//   while the output is stalled; s_tready drops only when that queue is full.
// Reset:
//   i_rst_n is synchronous, active low; it drops any pending escape and empties
//   the queue and the output register.
`default_nettype none

module url_percent_decoder #(
    parameter int QUEUE_DEPTH = urlpd_pkg::Q_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  wire logic        i_s_tlast,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,   // [7:0] out_byte
    output logic             o_m_tuser,   // [0] run_end
    output logic             o_m_tlast
);
    import urlpd_pkg::*;

    logic  q_full;
    logic  q_push;
    logic  q_valid;
    logic  q_pop;
    t_cmd  front_cmd;
    t_cmd  head_cmd;

    // Input side: escape tracking and record building.
    urlpd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (front_cmd)
    );

    // Record queue.
    urlpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (head_cmd),
        .i_pop   (q_pop)
    );

    // Output side: serialize record bytes.
    urlpd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_cmd        (head_cmd),
        .o_pop        (q_pop),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_byte       (o_m_tdata),
        .o_run_end    (o_m_tuser),
        .o_string_end (o_m_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/core/urlpd_front.sv =====
// Front end of the URL percent decoder: accepts input bytes, tracks pending
// escapes and turns each item into at most one work record. Depends on urlpd_pkg.
`default_nettype none

module urlpd_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic [7:0]     i_byte,
    input  wire logic           i_last,
    input  wire logic           i_q_full,
    output logic                o_push,
    output urlpd_pkg::t_cmd     o_cmd
);
    import urlpd_pkg::*;

    t_hold       r_stage;
    t_hold       n_stage;
    logic [7:0]  r_held;
    logic [7:0]  n_held;
    logic        accept;
    t_hex        d_hex;
    t_hex        c_hex;
    logic        take_c;
    logic [1:0]  cnt;
    logic [MAX_RES-1:0][7:0] outb;

    // An item is taken whenever the queue has room for its record.
    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    assign d_hex = hex_nibble(r_held);
    assign c_hex = hex_nibble(i_byte);

    // Decode one byte against the pending escape and collect its results.
    always_comb begin
        n_stage = r_stage;
        n_held  = r_held;
        cnt     = 2'd0;
        outb    = '0;
        take_c  = 1'b0;

        unique case (r_stage)
            HOLD_PCT: begin
                n_held  = i_byte;
                n_stage = HOLD_DIGIT;
            end
            HOLD_DIGIT: begin
                if (d_hex.ok && c_hex.ok) begin
                    outb[cnt] = {d_hex.val, c_hex.val};
                    cnt       = cnt + 2'd1;
                    n_stage   = HOLD_NONE;
                end else begin
                    outb[cnt] = CH_PERCENT;
                    cnt       = cnt + 2'd1;
                    if (r_held == CH_PERCENT) begin
                        // The held byte opens a new escape with this byte after it.
                        n_held  = i_byte;
                        n_stage = HOLD_DIGIT;
                    end else begin
                        outb[cnt] = plain_map(r_held);
                        cnt       = cnt + 2'd1;
                        take_c    = 1'b1;
                    end
                end
            end
            default: begin
                take_c = 1'b1;
            end
        endcase

        // Plain handling of the current byte.
        if (take_c) begin
            if (i_byte == CH_PERCENT) begin
                n_stage = HOLD_PCT;
            end else begin
                outb[cnt] = plain_map(i_byte);
                cnt       = cnt + 2'd1;
                n_stage   = HOLD_NONE;
            end
        end

        // At the end of the string everything still held goes out literally.
        if (i_last) begin
            if (n_stage == HOLD_PCT) begin
                outb[cnt] = CH_PERCENT;
                cnt       = cnt + 2'd1;
            end else if (n_stage == HOLD_DIGIT) begin
                outb[cnt] = CH_PERCENT;
                cnt       = cnt + 2'd1;
                outb[cnt] = plain_map(n_held);
                cnt       = cnt + 2'd1;
            end
            n_stage = HOLD_NONE;
        end
    end

    // Record toward the back end; items that only extend an escape push nothing.
    always_comb begin
        o_cmd.bytes = outb;
        o_cmd.cnt   = cnt;
        o_cmd.last  = i_last;
        o_push      = accept && (cnt != 2'd0);
    end

    // Escape state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= HOLD_NONE;
        end else if (accept) begin
            r_stage <= n_stage;
        end
    end

    // Held digit byte; it is only read after it has been written.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/urlpd_queue.sv =====
// Short queue of work records between the decoder front and back ends.
// Depends on urlpd_pkg for the record type; DEPTH must be at least 2.
`default_nettype none

module urlpd_queue #(
    parameter int DEPTH = urlpd_pkg::Q_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire urlpd_pkg::t_cmd  i_data,
    output logic                  o_full,
    output logic                  o_valid,
    output urlpd_pkg::t_cmd       o_data,
    input  wire logic             i_pop
);
    import urlpd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Record storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/urlpd_back.sv =====
// Back end of the URL percent decoder: walks the bytes of each work record
// into a registered output stage, one item per cycle while not stalled. Depends on urlpd_pkg.
`default_nettype none

module urlpd_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire urlpd_pkg::t_cmd  i_cmd,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [7:0]            o_byte,
    output logic                  o_run_end,
    output logic                  o_string_end
);
    import urlpd_pkg::*;

    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_run_end;
    logic        r_out_string_end;
    logic [1:0]  r_idx;
    logic        load;
    logic        last_of;

    // The output register takes a new item when empty or being drained.
    assign load    = i_valid && (!r_out_valid || i_ready);
    assign last_of = (r_idx == (i_cmd.cnt - 2'd1));
    assign o_pop   = load && last_of;

    // Position inside the current record.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (load) begin
            r_idx <= last_of ? 2'd0 : r_idx + 2'd1;
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte       <= i_cmd.bytes[r_idx];
            r_out_run_end    <= last_of;
            r_out_string_end <= last_of && i_cmd.last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_byte       = r_out_byte;
    assign o_run_end    = r_out_run_end;
    assign o_string_end = r_out_string_end;

endmodule

`default_nettype wire

// ===== rtl/core/urlpd_checker.sv =====
// Port-level checker for the URL percent decoder, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module urlpd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic [7:0]  i_s_tdata,
    input wire logic        i_s_tlast,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [7:0]  o_m_tdata,
    input wire logic        o_m_tuser,
    input wire logic        o_m_tlast
);

    // A stalled output item stays offered.
    `URLPD_ASSERT(a_m_valid_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid, "m_tvalid dropped")

    // A stalled output item keeps its byte.
    `URLPD_ASSERT(a_m_data_hold, o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata), "m_tdata changed")

    // The final byte of a string is always the last result of its input item.
    `URLPD_ASSERT(a_end_is_run_end, o_m_tvalid && o_m_tlast |-> o_m_tuser, "tlast without tuser")

    // Right after reset nothing is offered and input is taken.
    `URLPD_ASSERT_ALWAYS(a_reset_clean, $rose(i_rst_n) |-> !o_m_tvalid && o_s_tready, "bad reset")

endmodule

bind url_percent_decoder urlpd_checker u_urlpd_checker (.*);

`default_nettype wire
